FILE: hw/rtl/abb_pkg.sv
// abb_pkg: shared types and constants for the alpha bounding box unit
// no dependencies; used by abb_extent and alpha_bounding_box_unit
package abb_pkg;

    localparam int ALPHA_W = 8;
    localparam int REG_W   = 13;
    localparam int OUT_W   = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [REG_W-1:0] DIM_RESET = REG_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [OUT_W-1:0] top;
        logic [OUT_W-1:0] left;
        logic [OUT_W-1:0] right;
        logic [OUT_W-1:0] bottom;
    } t_box;

endpackage

FILE: hw/rtl/alpha_bounding_box_unit.sv
// alpha_bounding_box_unit: top level of the nonzero-alpha bounding box unit
// depends on abb_pkg and abb_extent
//
// usage
//   input channel: one alpha byte per beat, pixels in raster order (left to
//   right, then top to bottom); a beat is taken when i_in_valid is high and
//   o_in_stall is low
//   output channel: one beat per frame, carrying top, left, exclusive right
//   and exclusive bottom of the box round every pixel with nonzero alpha;
//   an empty frame gives top = bottom = height and left = right = width
//   config: i_cfg_we writes i_cfg_data into width (index 0) or height
//   (index 1); zero reads as 1, values above MAX_DIM as MAX_DIM
//   throughput: one pixel per clock while o_in_stall is low, set by the single extent update stage
//   pipeline: two register stages (input register, then result register);
//   the result register takes the box when the last pixel leaves the input register
//   reset: width and height go to 256, position and extent are cleared,
//   the output register is emptied
//   stall: the result register holds its beat while i_out_stall is high;
//   only a pending last pixel of the next frame waits on it, and o_in_stall
//   rises only in that case
module alpha_bounding_box_unit #(
    parameter int MAX_DIM = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [abb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [abb_pkg::REG_W-1:0]     i_cfg_data,
    // pixel input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [abb_pkg::ALPHA_W-1:0]   i_alpha,
    // box output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [abb_pkg::OUT_W-1:0]     o_box_top,
    output logic [abb_pkg::OUT_W-1:0]     o_box_left,
    output logic [abb_pkg::OUT_W-1:0]     o_box_right,
    output logic [abb_pkg::OUT_W-1:0]     o_box_bottom
);

    // config registers
    logic [abb_pkg::REG_W-1:0] r_image_width;
    logic [abb_pkg::REG_W-1:0] r_image_height;

    // input register
    logic                        r_in_valid;
    logic [abb_pkg::ALPHA_W-1:0] r_alpha;

    // result register
    logic          r_out_valid;
    abb_pkg::t_box r_box;

    logic          frame_end;
    abb_pkg::t_box box;
    logic          hold;
    logic          step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= abb_pkg::DIM_RESET;
            r_image_height <= abb_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (abb_pkg::t_cfg_idx'(i_cfg_index))
                abb_pkg::CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data;
                end
                abb_pkg::CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // the staged pixel waits only if it closes a frame and the result
    // register is full and stalled
    assign hold       = r_in_valid && frame_end && r_out_valid && i_out_stall;
    assign step       = r_in_valid && !hold;
    assign o_in_stall = hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!hold) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!hold && i_in_valid) begin
            r_alpha <= i_alpha;
        end
    end

    abb_extent #(
        .MAX_DIM (MAX_DIM)
    ) u_extent (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_alpha     (r_alpha),
        .i_width     (r_image_width),
        .i_height    (r_image_height),
        .o_frame_end (frame_end),
        .o_box       (box)
    );

    // result register: loads on the frame's last pixel, drains when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && frame_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && frame_end) begin
            r_box <= box;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_box_top    = r_box.top;
    assign o_box_left   = r_box.left;
    assign o_box_right  = r_box.right;
    assign o_box_bottom = r_box.bottom;

endmodule

FILE: hw/rtl/abb_extent.sv
// abb_extent: raster position counters and running extent of nonzero alpha
// depends on abb_pkg
module abb_extent #(
    parameter int MAX_DIM = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [abb_pkg::ALPHA_W-1:0] i_alpha,
    input  logic [abb_pkg::REG_W-1:0]   i_width,
    input  logic [abb_pkg::REG_W-1:0]   i_height,
    output logic                        o_frame_end,
    output abb_pkg::t_box               o_box
);

    localparam int CW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
    localparam int XW = (CW + 1 > abb_pkg::REG_W) ? CW + 1 : abb_pkg::REG_W;
    localparam logic [XW-1:0] DIM_MAX = XW'(MAX_DIM);

    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;
    logic [CW-1:0] r_min_col, n_min_col;
    logic [CW-1:0] r_max_col, n_max_col;
    logic [CW-1:0] r_min_row, n_min_row;
    logic [CW-1:0] r_max_row, n_max_row;
    logic          r_seen, n_seen;

    logic [XW-1:0] w_x, h_x;
    logic          row_end;
    logic          frame_end;
    logic [XW-1:0] top_x, left_x, right_x, bottom_x;

    // clamp dimensions to 1..MAX_DIM
    always_comb begin
        w_x = XW'(i_width);
        h_x = XW'(i_height);
        if (w_x == '0) begin
            w_x = XW'(1);
        end else if (w_x > DIM_MAX) begin
            w_x = DIM_MAX;
        end
        if (h_x == '0) begin
            h_x = XW'(1);
        end else if (h_x > DIM_MAX) begin
            h_x = DIM_MAX;
        end
    end

    assign row_end   = XW'(r_col) >= (w_x - XW'(1));
    assign frame_end = row_end && (XW'(r_row) >= (h_x - XW'(1)));
    assign o_frame_end = frame_end;

    // extent after this pixel
    always_comb begin
        n_min_col = r_min_col;
        n_max_col = r_max_col;
        n_min_row = r_min_row;
        n_max_row = r_max_row;
        n_seen    = r_seen;
        if (i_alpha != '0) begin
            n_seen = 1'b1;
            if (!r_seen) begin
                n_min_col = r_col;
                n_max_col = r_col;
                n_min_row = r_row;
                n_max_row = r_row;
            end else begin
                if (r_col < r_min_col) begin
                    n_min_col = r_col;
                end
                if (r_col > r_max_col) begin
                    n_max_col = r_col;
                end
                if (r_row < r_min_row) begin
                    n_min_row = r_row;
                end
                if (r_row > r_max_row) begin
                    n_max_row = r_row;
                end
            end
        end
        if (row_end) begin
            n_col = '0;
            n_row = r_row + CW'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    // box as seen at the frame's last pixel
    always_comb begin
        if (n_seen) begin
            top_x    = XW'(n_min_row);
            left_x   = XW'(n_min_col);
            right_x  = XW'(n_max_col) + XW'(1);
            bottom_x = XW'(n_max_row) + XW'(1);
        end else begin
            top_x    = h_x;
            left_x   = w_x;
            right_x  = w_x;
            bottom_x = h_x;
        end
        o_box.top    = top_x[abb_pkg::OUT_W-1:0];
        o_box.left   = left_x[abb_pkg::OUT_W-1:0];
        o_box.right  = right_x[abb_pkg::OUT_W-1:0];
        o_box.bottom = bottom_x[abb_pkg::OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_min_col <= '0;
            r_max_col <= '0;
            r_min_row <= '0;
            r_max_row <= '0;
            r_seen    <= 1'b0;
        end else if (i_step) begin
            if (frame_end) begin
                r_col     <= '0;
                r_row     <= '0;
                r_min_col <= '0;
                r_max_col <= '0;
                r_min_row <= '0;
                r_max_row <= '0;
                r_seen    <= 1'b0;
            end else begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_min_col <= n_min_col;
                r_max_col <= n_max_col;
                r_min_row <= n_min_row;
                r_max_row <= n_max_row;
                r_seen    <= n_seen;
            end
        end
    end

endmodule
